// ===== src/lsb_stego_crc8_codec_defines.svh =====
// Assertion macros shared by the codec RTL files.
`ifndef LSB_STEGO_CRC8_CODEC_DEFINES_SVH
`define LSB_STEGO_CRC8_CODEC_DEFINES_SVH

`ifndef SYNTH
// Concurrent check on clk, idle while rst_n is low.
`define LSC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lsc assertion failed");
// Expression must never be true.
`define LSC_ASSERT_NEVER(label, expr) \
    `LSC_ASSERT(label, !(expr))
`else
`define LSC_ASSERT(label, prop)
`define LSC_ASSERT_NEVER(label, expr)
`endif

`endif

// ===== src/lsc_pkg.sv =====
// Shared types, constants and CRC helper for the LSB stego CRC-8 codec.
package lsc_pkg;

    localparam int NUM_LANES = 8;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // direction register codes
    localparam logic DIR_EMBED   = 1'b0;
    localparam logic DIR_EXTRACT = 1'b1;

    // embed opcodes
    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_CRC     = 1'b1;

    typedef enum logic [2:0] {
        ST_EMBEDDED   = 3'd0,
        ST_CHARACTER  = 3'd1,
        ST_TERMINATOR = 3'd2,
        ST_CRC_PASS   = 3'd3,
        ST_CRC_FAIL   = 3'd4
    } status_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] message_byte;
        logic [7:0] cover_0;
        logic [7:0] cover_1;
        logic [7:0] cover_2;
        logic [7:0] cover_3;
        logic [7:0] cover_4;
        logic [7:0] cover_5;
        logic [7:0] cover_6;
        logic [7:0] cover_7;
    } in_item_t;

    typedef struct packed {
        logic [7:0] stego_0;
        logic [7:0] stego_1;
        logic [7:0] stego_2;
        logic [7:0] stego_3;
        logic [7:0] stego_4;
        logic [7:0] stego_5;
        logic [7:0] stego_6;
        logic [7:0] stego_7;
        logic [7:0] extracted_byte;
        status_t    status;
    } out_item_t;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic [7:0] stego;
        logic [7:0] contrib;
    } lane_out_t;

    // Push a CRC register through nbytes zero bytes (linear, folds to XOR gates)
    function automatic logic [7:0] crc_advance(input logic [7:0] c, input int nbytes);
        logic [7:0] r;
        r = c;
        for (int k = 0; k < 8 * NUM_LANES; k++) begin
            if (k < nbytes * 8) begin
                r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== src/lsb_stego_crc8_codec.sv =====
// Top level of the LSB steganography codec with running CRC-8 check.
//
// Channels: in_valid/in_ready/in_data carries one group of eight cover bytes plus
// opcode and message byte; out_valid/out_ready/out_data returns one result item per
// input item; cfg_valid/cfg_ready/cfg_data writes the direction bit (0 embed,
// 1 extract and check). cfg_ready is always high; write it only while idle.
// Timing: a result is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while out_ready is high. Eight byte lanes work in
// parallel and a merge stage folds their CRC shares into the running CRC in the same
// cycle, so the CRC feedback register sets the rate.
// Reset: running CRC returns to 0xFF, message phase, direction embed, output empty.
// Stall: the output register holds its item while out_ready is low; a new item is
// still taken in the cycle that the held item leaves (in_ready follows out_ready).
module lsb_stego_crc8_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lsc_pkg::out_item_t out_data
);
    import lsc_pkg::*;

    logic              direction_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg, out_data_next;
    logic              accept;
    logic [7:0]        cover_bytes [NUM_LANES];
    logic [7:0]        src_byte;
    logic [7:0]        running_crc;
    logic [7:0]        gathered;
    status_t           status;
    lane_out_t         lanes [NUM_LANES];

    // config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg <= DIR_EMBED;
        end else if (cfg_valid && cfg_ready) begin
            direction_reg <= cfg_data;
        end
    end

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // unpack cover bytes
    assign cover_bytes[0] = in_data.cover_0;
    assign cover_bytes[1] = in_data.cover_1;
    assign cover_bytes[2] = in_data.cover_2;
    assign cover_bytes[3] = in_data.cover_3;
    assign cover_bytes[4] = in_data.cover_4;
    assign cover_bytes[5] = in_data.cover_5;
    assign cover_bytes[6] = in_data.cover_6;
    assign cover_bytes[7] = in_data.cover_7;

    // bits to hide: message byte or the running CRC
    assign src_byte = (in_data.opcode == OP_CRC) ? running_crc : in_data.message_byte;

    // byte lanes
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lsc_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .direction  (direction_reg),
            .src_bit    (src_byte[g]),
            .cover_byte (cover_bytes[g]),
            .lane_out   (lanes[g])
        );
    end

    lsc_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .direction   (direction_reg),
        .opcode      (in_data.opcode),
        .lanes       (lanes),
        .running_crc (running_crc),
        .gathered    (gathered),
        .status      (status)
    );

    // result assembly
    always_comb
    begin
        out_data_next.stego_0        = lanes[0].stego;
        out_data_next.stego_1        = lanes[1].stego;
        out_data_next.stego_2        = lanes[2].stego;
        out_data_next.stego_3        = lanes[3].stego;
        out_data_next.stego_4        = lanes[4].stego;
        out_data_next.stego_5        = lanes[5].stego;
        out_data_next.stego_6        = lanes[6].stego;
        out_data_next.stego_7        = lanes[7].stego;
        out_data_next.extracted_byte = gathered;
        out_data_next.status         = status;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/lsc_lane.sv =====
// One byte lane: LSB replacement and this byte's share of the group CRC.
module lsc_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic              direction,
    input  logic              src_bit,
    input  logic [7:0]        cover_byte,
    output lsc_pkg::lane_out_t lane_out
);
    import lsc_pkg::*;

    logic [7:0] stego;

    // embed replaces the LSB, extract passes the byte through
    assign stego = (direction == DIR_EMBED) ? {cover_byte[7:1], src_bit} : cover_byte;

    // byte LANE_IDX is followed by the remaining bytes of the group
    assign lane_out.stego   = stego;
    assign lane_out.contrib = crc_advance(stego, NUM_LANES - LANE_IDX);

endmodule

// ===== src/lsc_merge.sv =====
// Merge stage: gathers lane LSBs, folds lane CRC shares, keeps CRC and phase state.
`include "lsb_stego_crc8_codec_defines.svh"

module lsc_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               direction,
    input  logic               opcode,
    input  lsc_pkg::lane_out_t lanes [lsc_pkg::NUM_LANES],
    output logic [7:0]         running_crc,
    output logic [7:0]         gathered,
    output lsc_pkg::status_t   status
);
    import lsc_pkg::*;

    logic [7:0] running_crc_reg, running_crc_next;
    logic       expect_check_reg, expect_check_next;
    logic [7:0] group_crc;
    logic [7:0] contrib_xor;

    assign running_crc = running_crc_reg;

    // LSB gather and XOR of the lane shares
    always_comb
    begin
        contrib_xor = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            gathered[i] = lanes[i].stego[0];
            contrib_xor = contrib_xor ^ lanes[i].contrib;
        end
    end

    assign group_crc = crc_advance(running_crc_reg, NUM_LANES) ^ contrib_xor;

    // status and next state
    always_comb
    begin
        running_crc_next  = running_crc_reg;
        expect_check_next = expect_check_reg;
        status            = ST_EMBEDDED;
        if (direction == DIR_EMBED) begin
            running_crc_next = (opcode == OP_CRC) ? CRC_INIT : group_crc;
        end else if (expect_check_reg) begin
            status            = (gathered == running_crc_reg) ? ST_CRC_PASS : ST_CRC_FAIL;
            running_crc_next  = CRC_INIT;
            expect_check_next = 1'b0;
        end else begin
            running_crc_next  = group_crc;
            status            = (gathered == 8'd0) ? ST_TERMINATOR : ST_CHARACTER;
            expect_check_next = (gathered == 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            running_crc_reg  <= CRC_INIT;
            expect_check_reg <= 1'b0;
        end else if (accept) begin
            running_crc_reg  <= running_crc_next;
            expect_check_reg <= expect_check_next;
        end
    end

    // check group always restarts the CRC and returns to message phase
    `LSC_ASSERT(a_check_restarts, (accept && direction == DIR_EXTRACT && expect_check_reg) |=> (!expect_check_reg && running_crc_reg == CRC_INIT))
    // CRC group in embed restarts the CRC
    `LSC_ASSERT(a_crc_group_restarts, (accept && direction == DIR_EMBED && opcode == OP_CRC) |=> (running_crc_reg == CRC_INIT))
    // check phase is entered only by an extract item
    `LSC_ASSERT(a_phase_entry, $rose(expect_check_reg) |-> $past(accept && direction == DIR_EXTRACT))
    // state holds while nothing is accepted
    `LSC_ASSERT_NEVER(a_state_hold, !$past(accept) && !$stable(running_crc_reg) && $past(rst_n))

endmodule
